@@ rtl/be3_pkg.sv @@
// ----------------------------------------------------------------------------
// be3_pkg
// Shared types and constants of the 3x3 binary erosion block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package be3_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_HEIGHT    = 4096;
  localparam int RESET_WIDTH   = 640;
  localparam int RESET_HEIGHT  = 480;
  localparam int MIN_SIZE      = 3;

  localparam int IMG_W_BITS = 11;
  localparam int IMG_H_BITS = 13;
  localparam int ROW_W      = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_IMAGE_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_IMAGE_HEIGHT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_EIGHT_CONNECTED = 2'd2;

  localparam int COL_BITS = 3;
  localparam int WIN_BITS = 3 * COL_BITS;
  localparam int LB_W     = 2;

  localparam logic [WIN_BITS-1:0] CROSS_MASK = 9'h0BA;
  localparam logic [WIN_BITS-1:0] FULL_MASK  = 9'h1FF;

  typedef struct packed {
    logic       action;
    logic [7:0] pixel_byte;
  } in_item_t;

  typedef struct packed {
    logic eroded_pixel;
    logic frame_last;
  } out_item_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } win_ctl_t;

endpackage

`default_nettype wire

@@ rtl/be3_line_buf.sv @@
// ----------------------------------------------------------------------------
// be3_line_buf
// Line buffer memory: per column, the pixel of the row above and two above.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module be3_line_buf #(
  parameter int DEPTH = be3_pkg::MAX_WIDTH_DEF,
  parameter int AW    = 10
) (
  input  wire logic                    clk,
  input  wire logic                    rd_en,
  input  wire logic [AW-1:0]           rd_addr,
  output logic      [be3_pkg::LB_W-1:0] rd_data,
  input  wire logic                    wr_en,
  input  wire logic [AW-1:0]           wr_addr,
  input  wire logic [be3_pkg::LB_W-1:0] wr_data
);
  import be3_pkg::*;

  logic [LB_W-1:0] mem [DEPTH];
  logic [LB_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ rtl/be3_win_cell.sv @@
// ----------------------------------------------------------------------------
// be3_win_cell
// One column of the 3x3 window; shifts to its neighbor on every beat, or loads zero on a clear beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module be3_win_cell (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire be3_pkg::win_ctl_t             ctl,
  input  wire logic [be3_pkg::COL_BITS-1:0]  col_in,
  output logic      [be3_pkg::COL_BITS-1:0]  col_out
);
  import be3_pkg::*;

  logic [COL_BITS-1:0] col_r;
  logic [COL_BITS-1:0] col_nxt;

  always_comb begin
    col_nxt = col_r;
    if (ctl.shift) begin
      col_nxt = ctl.clear ? '0 : col_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else begin
      col_r <= col_nxt;
    end
  end

  assign col_out = col_r;

endmodule

`default_nettype wire

@@ rtl/binary_erosion_3x3_top.sv @@
// Stage 1 holds each input beat while its line-buffer read lands, then the
// output register holds its result. Items that give no result leave no beat.
// Throughput: one item per cycle unless out_ready stalls; one line-buffer read
// and write per cycle; the three-cell window chain shifts once per item.
// Reset: synchronous, active low; clears counters, window and valid flags and
// loads width 640, height 480, 4-neighbour mode. Line buffers are not cleared.
// ----------------------------------------------------------------------------
// binary_erosion_3x3_top
// 3x3 binary erosion over a raster pixel stream with a line buffer of two rows.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module binary_erosion_3x3_top #(
  parameter int MAX_WIDTH = be3_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire be3_pkg::in_item_t               in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output be3_pkg::out_item_t                   out_data,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [be3_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [be3_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import be3_pkg::*;

  localparam int CW    = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int RST_W = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;

  // configuration
  logic [WW-1:0]    eff_w_r, eff_w_nxt;
  logic [ROW_W-1:0] eff_h_r, eff_h_nxt;
  logic             eight_r, eight_nxt;
  logic [IMG_W_BITS-1:0] w_val;
  logic [IMG_H_BITS-1:0] h_val;
  logic [WW-1:0]    w_clamp;
  logic [ROW_W-1:0] h_clamp;
  logic             cfg_wr;

  // position counters
  logic [CW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [WW-1:0]    col_ext, col_inc;
  logic             frame_end, emit, interior, pix_fg, accept;

  // stage 1
  logic             s1_v_r, s1_v_nxt;
  logic             s1_pix_r, s1_emit_r, s1_int_r, s1_last_r;
  logic [CW-1:0]    s1_addr_r;
  logic             s1_adv;

  // line buffer and window
  logic [LB_W-1:0]     lb_rd;
  logic [LB_W-1:0]     lb_wr;
  logic [COL_BITS-1:0] col_new, q2, q1, q0;
  logic [WIN_BITS-1:0] win_nxt, mask;
  win_ctl_t            win_ctl;
  logic                res;

  // output
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;

  // configuration port
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign w_val     = cfg_data[IMG_W_BITS-1:0];
  assign h_val     = cfg_data[IMG_H_BITS-1:0];

  always_comb begin
    if (int'(w_val) < MIN_SIZE) begin
      w_clamp = WW'(MIN_SIZE);
    end else if (int'(w_val) > MAX_WIDTH) begin
      w_clamp = WW'(MAX_WIDTH);
    end else begin
      w_clamp = WW'(w_val);
    end
    if (int'(h_val) < MIN_SIZE) begin
      h_clamp = ROW_W'(MIN_SIZE);
    end else if (int'(h_val) > MAX_HEIGHT) begin
      h_clamp = ROW_W'(MAX_HEIGHT);
    end else begin
      h_clamp = ROW_W'(h_val);
    end
  end

  always_comb begin
    eff_w_nxt = eff_w_r;
    eff_h_nxt = eff_h_r;
    eight_nxt = eight_r;
    if (cfg_wr) begin
      unique case (cfg_index)
        CFG_IDX_IMAGE_WIDTH:     eff_w_nxt = w_clamp;
        CFG_IDX_IMAGE_HEIGHT:    eff_h_nxt = h_clamp;
        CFG_IDX_EIGHT_CONNECTED: eight_nxt = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_w_r <= WW'(RST_W);
      eff_h_r <= ROW_W'(RESET_HEIGHT);
      eight_r <= 1'b0;
    end else begin
      eff_w_r <= eff_w_nxt;
      eff_h_r <= eff_h_nxt;
      eight_r <= eight_nxt;
    end
  end

  // input side: position and border decisions
  assign accept    = in_valid && in_ready;
  assign pix_fg    = !in_data.action && (in_data.pixel_byte != '0);
  assign col_ext   = WW'(col_r);
  assign col_inc   = col_ext + WW'(1);
  assign frame_end = (col_r == '0) &&
                     ({1'b0, row_r} >= ({1'b0, eff_h_r} + (ROW_W+1)'(1)));
  assign emit      = (row_r >= ROW_W'(2)) || ((row_r == ROW_W'(1)) && (col_r != '0));
  assign interior  = (col_ext >= WW'(2)) && (col_ext < eff_w_r) &&
                     (row_r >= ROW_W'(2)) && (row_r < eff_h_r);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (frame_end) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (col_inc >= eff_w_r) begin
        col_nxt = '0;
        row_nxt = row_r + ROW_W'(1);
      end else begin
        col_nxt = CW'(col_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // stage 1: hold the item while the line-buffer read lands
  assign s1_adv   = s1_v_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_v_r || s1_adv;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (accept) begin
      s1_v_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r  <= pix_fg;
      s1_emit_r <= emit;
      s1_int_r  <= interior;
      s1_last_r <= frame_end;
      s1_addr_r <= col_r;
    end
  end

  assign lb_wr = {s1_pix_r, lb_rd[1]};

  be3_line_buf #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_buf (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col_r),
    .rd_data (lb_rd),
    .wr_en   (s1_adv),
    .wr_addr (s1_addr_r),
    .wr_data (lb_wr)
  );

  // window chain: newest column enters cell 2
  assign col_new       = {s1_pix_r, lb_rd[1], lb_rd[0]};
  assign win_ctl.shift = s1_adv;
  assign win_ctl.clear = s1_last_r;

  be3_win_cell u_cell2 (.clk(clk), .rst_n(rst_n), .ctl(win_ctl), .col_in(col_new), .col_out(q2));
  be3_win_cell u_cell1 (.clk(clk), .rst_n(rst_n), .ctl(win_ctl), .col_in(q2),      .col_out(q1));
  be3_win_cell u_cell0 (.clk(clk), .rst_n(rst_n), .ctl(win_ctl), .col_in(q1),      .col_out(q0));

  assign win_nxt = {col_new, q2, q1};
  assign mask    = eight_r ? FULL_MASK : CROSS_MASK;
  assign res     = s1_int_r && ((win_nxt & mask) == mask);

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = s1_emit_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r.eroded_pixel <= res;
      out_data_r.frame_last   <= s1_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_v_r)
    else $error("accepted beat did not reach stage 1");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && out_valid_r && !out_ready) |-> !in_ready)
    else $error("input taken while pipeline stalled");

  a_last_is_background: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.frame_last && out_data.eroded_pixel))
    else $error("frame_last beat carries foreground");

  a_window_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_last_r) |=> (q2 == '0 && q1 == '0 && q0 == '0))
    else $error("window not cleared at frame end");
`endif

endmodule

`default_nettype wire
